// ----- rtl/dht_pkg.sv -----
package dht_pkg;

  // payload widths
  localparam int KEY_W    = 31;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 5;

  // table size after reset
  localparam logic [CFG_W-1:0] SIZE_RESET = 5'd13;

  // largest table size the size register can name
  localparam int SIZE_MAX = (1 << CFG_W) - 1;

  // nibble-serial modulo unit geometry
  localparam int DIGIT_W = 4;
  localparam int OP_W    = ((KEY_W + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
  localparam int NDIG    = OP_W / DIGIT_W;
  localparam int DC_W    = $clog2(NDIG + 1);

  // operation kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_NO_FREE   = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  // slots that can ever be addressed for a given storage depth
  function automatic int used_slots(input int depth);
    return (depth < SIZE_MAX) ? depth : SIZE_MAX;
  endfunction

  // controller to datapath commands
  typedef struct packed {
    logic    load_key;
    logic    red_start;
    logic    red_sel_step;
    logic    cap_home;
    logic    cap_smod;
    logic    idx_adv;
    logic    mem_rd;
    logic    mem_wr;
    logic    rsp_load;
    status_e rsp_status;
    logic    rsp_slot_en;
  } dht_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic red_done;
    logic is_search;
    logic occ_full;
    logic cur_valid;
    logic rd_valid;
    logic key_match;
    logic last_probe;
    logic rsp_free;
  } dht_sts_t;

endpackage

// ----- rtl/dht_if.sv -----
// request channel: operation kind and key
interface dht_req_if;
  import dht_pkg::*;

  logic             valid;
  logic             ready;
  logic             kind;
  logic [KEY_W-1:0] key;

  modport source (output valid, kind, key, input ready);
  modport sink   (input valid, kind, key, output ready);
endinterface

// response channel: status and slot
interface dht_rsp_if #(
  parameter int SLOT_W = 4
);
  import dht_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;

  modport source (output valid, status, slot, input ready);
  modport sink   (input valid, status, slot, output ready);
endinterface

// configuration write channel: table size
interface dht_cfg_if;
  import dht_pkg::*;

  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/dht_modred.sv -----
module dht_modred #(
  parameter int STEP_PRIME = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dht_pkg::OP_W-1:0]    opnd_i,
  input  logic [dht_pkg::DC_W-1:0]    ndig_i,
  input  logic [dht_pkg::CFG_W-1:0]   n_i,
  output logic                        done_o,
  output logic [dht_pkg::CFG_W-1:0]   rem_n_o,
  output logic [$clog2(STEP_PRIME)-1:0] rem_p_o
);
  import dht_pkg::*;

  localparam int P_W = $clog2(STEP_PRIME);

  logic [OP_W-1:0]  opnd_q;
  logic [DC_W-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [CFG_W-1:0] rn_q, rn_d;
  logic [P_W-1:0]   rp_q, rp_d;

  // fold one nibble into both remainders, msb first
  always_comb begin
    logic [CFG_W:0] tn;
    logic [P_W:0]   tp;
    logic [CFG_W:0] n_ext;
    logic [P_W:0]   p_ext;
    n_ext = {1'b0, n_i};
    p_ext = (P_W + 1)'(STEP_PRIME);
    tn = {1'b0, rn_q};
    tp = {1'b0, rp_q};
    for (int b = DIGIT_W - 1; b >= 0; b--) begin
      tn = {tn[CFG_W-1:0], opnd_q[OP_W - DIGIT_W + b]};
      if (tn >= n_ext) begin
        tn = tn - n_ext;
      end
      tp = {tp[P_W-1:0], opnd_q[OP_W - DIGIT_W + b]};
      if (tp >= p_ext) begin
        tp = tp - p_ext;
      end
    end
    rn_d = tn[CFG_W-1:0];
    rp_d = tp[P_W-1:0];
  end

  // digit counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == DC_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= ndig_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - DC_W'(1);
        if (cnt_q == DC_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // operand shifter and remainders
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      opnd_q <= opnd_i;
      rn_q   <= '0;
      rp_q   <= '0;
    end else if (busy_q) begin
      opnd_q <= opnd_q << DIGIT_W;
      rn_q   <= rn_d;
      rp_q   <= rp_d;
    end
  end

  assign done_o  = done_q;
  assign rem_n_o = rn_q;
  assign rem_p_o = rp_q;

endmodule

// ----- rtl/dht_dp.sv -----
module dht_dp #(
  parameter int TABLE_DEPTH = 16,
  parameter int PROBE_LIMIT = 10,
  parameter int STEP_PRIME  = 7,
  parameter int IDX_W       = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dht_pkg::dht_cmd_t            cmd_i,
  output dht_pkg::dht_sts_t            sts_o,
  input  logic                         req_kind_i,
  input  logic [dht_pkg::KEY_W-1:0]    req_key_i,
  input  logic                         cfg_valid_i,
  input  logic [dht_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                         rsp_ready_i,
  output logic                         rsp_valid_o,
  output logic [dht_pkg::STATUS_W-1:0] rsp_status_o,
  output logic [IDX_W-1:0]             rsp_slot_o
);
  import dht_pkg::*;

  localparam int USED     = used_slots(TABLE_DEPTH);
  localparam int OCC_W    = $clog2(USED + 1);
  localparam int PC_W     = $clog2(PROBE_LIMIT + 1);
  localparam int P_W      = $clog2(STEP_PRIME);
  localparam int SP_W     = $clog2(STEP_PRIME + 1);
  localparam int STEP_DIG = (SP_W + DIGIT_W - 1) / DIGIT_W;

  logic [CFG_W-1:0]    size_q;
  logic [CFG_W-1:0]    n_eff;
  logic                kind_q;
  logic [KEY_W-1:0]    key_q;
  logic [SP_W-1:0]     step_q;
  logic [IDX_W-1:0]    idx_q;
  logic [IDX_W-1:0]    smod_q;
  logic [PC_W-1:0]     pcnt_q;
  logic [OCC_W-1:0]    occ_q;
  logic [USED-1:0]     valid_q;
  logic [KEY_W-1:0]    key_mem_q [USED];
  logic [KEY_W-1:0]    rd_key_q;
  logic                rd_valid_q;
  logic                rsp_valid_q;
  logic [STATUS_W-1:0] rsp_status_q;
  logic [IDX_W-1:0]    rsp_slot_q;

  logic [OP_W-1:0]     red_opnd;
  logic [OP_W-1:0]     step_al;
  logic [DC_W-1:0]     red_ndig;
  logic                red_done;
  logic [CFG_W-1:0]    rem_n;
  logic [P_W-1:0]      rem_p;
  logic [IDX_W:0]      idx_sum;
  logic [IDX_W:0]      n_idx;
  logic [IDX_W-1:0]    idx_next;

  // effective table size: zero acts as one, clamp to the storage depth
  always_comb begin
    if (size_q == '0) begin
      n_eff = CFG_W'(1);
    end else if (size_q > CFG_W'(USED)) begin
      n_eff = CFG_W'(USED);
    end else begin
      n_eff = size_q;
    end
  end

  // size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (cfg_valid_i) begin
      size_q <= cfg_data_i;
    end
  end

  // modulo unit operand: the key, or the step left-aligned
  assign step_al  = OP_W'(step_q) << (OP_W - DIGIT_W * STEP_DIG);
  assign red_opnd = cmd_i.red_sel_step ? step_al : OP_W'(req_key_i);
  assign red_ndig = cmd_i.red_sel_step ? DC_W'(STEP_DIG) : DC_W'(NDIG);

  dht_modred #(
    .STEP_PRIME (STEP_PRIME)
  ) u_modred (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.red_start),
    .opnd_i  (red_opnd),
    .ndig_i  (red_ndig),
    .n_i     (n_eff),
    .done_o  (red_done),
    .rem_n_o (rem_n),
    .rem_p_o (rem_p)
  );

  // next probe slot: add the reduced step, wrap once
  assign n_idx   = (IDX_W + 1)'(n_eff);
  assign idx_sum = {1'b0, idx_q} + {1'b0, smod_q};
  assign idx_next = (idx_sum >= n_idx) ? IDX_W'(idx_sum - n_idx) : IDX_W'(idx_sum);

  // operation registers and probe position
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_key) begin
      kind_q <= req_kind_i;
      key_q  <= req_key_i;
    end
    if (cmd_i.cap_home) begin
      idx_q  <= IDX_W'(rem_n);
      step_q <= SP_W'(STEP_PRIME) - SP_W'(rem_p);
    end else if (cmd_i.idx_adv) begin
      idx_q <= idx_next;
    end
    if (cmd_i.cap_smod) begin
      smod_q <= IDX_W'(rem_n);
    end
    if (cmd_i.cap_home) begin
      pcnt_q <= '0;
    end else if (cmd_i.idx_adv) begin
      pcnt_q <= pcnt_q + PC_W'(1);
    end
  end

  // valid bits and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
    end else if (cmd_i.mem_wr) begin
      valid_q[idx_q] <= 1'b1;
      occ_q          <= occ_q + OCC_W'(1);
    end
  end

  // key memory, one port, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      key_mem_q[idx_q] <= key_q;
    end
    if (cmd_i.mem_rd) begin
      rd_key_q   <= key_mem_q[idx_q];
      rd_valid_q <= valid_q[idx_q];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.rsp_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rsp_load) begin
      rsp_status_q <= cmd_i.rsp_status;
      rsp_slot_q   <= cmd_i.rsp_slot_en ? idx_q : '0;
    end
  end

  assign rsp_valid_o  = rsp_valid_q;
  assign rsp_status_o = rsp_status_q;
  assign rsp_slot_o   = rsp_slot_q;

  // status back to the controller
  always_comb begin
    sts_o            = '0;
    sts_o.red_done   = red_done;
    sts_o.is_search  = (kind_q == KIND_SEARCH);
    sts_o.occ_full   = ((CFG_W + 1)'(occ_q) >= (CFG_W + 1)'(n_eff));
    sts_o.cur_valid  = valid_q[idx_q];
    sts_o.rd_valid   = rd_valid_q;
    sts_o.key_match  = (rd_key_q == key_q);
    sts_o.last_probe = (pcnt_q == PC_W'(PROBE_LIMIT));
    sts_o.rsp_free   = !rsp_valid_q || rsp_ready_i;
  end

endmodule

// ----- rtl/dht_ctrl.sv -----
module dht_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  dht_pkg::dht_sts_t sts_i,
  output dht_pkg::dht_cmd_t cmd_o
);
  import dht_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH_KEY,
    S_STEP_START,
    S_HASH_STEP,
    S_INS_PROBE,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_RESPOND
  } state_e;

  state_e  state_q;
  status_e res_status_q;
  logic    res_slot_en_q;

  // state and held result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      res_status_q  <= ST_INSERTED;
      res_slot_en_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            state_q <= S_HASH_KEY;
          end
        end
        S_HASH_KEY: begin
          if (sts_i.red_done) begin
            state_q <= S_STEP_START;
          end
        end
        S_STEP_START: begin
          state_q <= S_HASH_STEP;
        end
        S_HASH_STEP: begin
          if (sts_i.red_done) begin
            if (sts_i.is_search) begin
              state_q <= S_SRCH_RD;
            end else if (sts_i.occ_full) begin
              res_status_q  <= ST_FULL;
              res_slot_en_q <= 1'b0;
              state_q       <= S_RESPOND;
            end else begin
              state_q <= S_INS_PROBE;
            end
          end
        end
        S_INS_PROBE: begin
          if (!sts_i.cur_valid) begin
            res_status_q  <= ST_INSERTED;
            res_slot_en_q <= 1'b1;
            state_q       <= S_RESPOND;
          end else if (sts_i.last_probe) begin
            res_status_q  <= ST_NO_FREE;
            res_slot_en_q <= 1'b0;
            state_q       <= S_RESPOND;
          end
        end
        S_SRCH_RD: begin
          state_q <= S_SRCH_CHK;
        end
        S_SRCH_CHK: begin
          if (!sts_i.rd_valid) begin
            res_status_q  <= ST_NOT_FOUND;
            res_slot_en_q <= 1'b0;
            state_q       <= S_RESPOND;
          end else if (sts_i.key_match) begin
            res_status_q  <= ST_FOUND;
            res_slot_en_q <= 1'b1;
            state_q       <= S_RESPOND;
          end else if (sts_i.last_probe) begin
            res_status_q  <= ST_NOT_FOUND;
            res_slot_en_q <= 1'b0;
            state_q       <= S_RESPOND;
          end else begin
            state_q <= S_SRCH_RD;
          end
        end
        S_RESPOND: begin
          if (sts_i.rsp_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign req_ready_o = (state_q == S_IDLE);

  // datapath commands
  always_comb begin
    cmd_o             = '0;
    cmd_o.rsp_status  = res_status_q;
    cmd_o.rsp_slot_en = res_slot_en_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load_key  = req_valid_i;
        cmd_o.red_start = req_valid_i;
      end
      S_HASH_KEY: begin
        cmd_o.cap_home = sts_i.red_done;
      end
      S_STEP_START: begin
        cmd_o.red_start    = 1'b1;
        cmd_o.red_sel_step = 1'b1;
      end
      S_HASH_STEP: begin
        cmd_o.cap_smod = sts_i.red_done;
      end
      S_INS_PROBE: begin
        cmd_o.mem_wr  = !sts_i.cur_valid;
        cmd_o.idx_adv = sts_i.cur_valid && !sts_i.last_probe;
      end
      S_SRCH_RD: begin
        cmd_o.mem_rd = 1'b1;
      end
      S_SRCH_CHK: begin
        cmd_o.idx_adv = sts_i.rd_valid && !sts_i.key_match && !sts_i.last_probe;
      end
      S_RESPOND: begin
        cmd_o.rsp_load = sts_i.rsp_free;
      end
      default: begin
        cmd_o.rsp_load = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/double_hash_table_top.sv -----
// Open-addressing hash table with double hashing, one operation at a time.
// A request inserts or looks up a 31-bit key; each request returns exactly one
// response carrying a status and a slot. The home slot is the key modulo the
// configured table size (zero acts as one, values above the storage depth are
// clamped) and the probe step is STEP_PRIME minus the key modulo STEP_PRIME.
// Insert answers "table full" when the occupancy has reached the size,
// otherwise it takes the first empty slot among the home slot and up to
// PROBE_LIMIT further probes; duplicates are not checked. Search stops at the
// first empty slot or matching key. Both modulo results come from a shared
// nibble-serial unit, first for the key (eight nibbles) and then for the
// step (one or two nibbles). Each insert probe then tests the valid bit of
// its slot directly, while each search probe passes through a read state and
// a check state, for the single registered read port of the key memory. The
// response is then loaded once the output register is free, and the
// controller returns to idle before the next request transfer. An operation
// makes 1 to PROBE_LIMIT + 1 probes, or none for an insert into a full table.
// A new request is taken while the previous response still waits in the
// output register.
// The size register should be written only while no operation is in flight;
// stored entries and occupancy survive a size change.
module double_hash_table_top #(
  parameter int TABLE_DEPTH = 16,
  parameter int PROBE_LIMIT = 10,
  parameter int STEP_PRIME  = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dht_req_if.sink     req_if,
  dht_rsp_if.source   rsp_if,
  dht_cfg_if.sink     cfg_if
);
  import dht_pkg::*;

  localparam int USED  = used_slots(TABLE_DEPTH);
  localparam int IDX_W = $clog2(USED);

  dht_cmd_t         cmd;
  dht_sts_t         sts;
  logic [IDX_W-1:0] rsp_slot;

  // size register always takes a write
  assign cfg_if.ready = 1'b1;

  dht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_if.valid),
    .req_ready_o (req_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dht_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PROBE_LIMIT (PROBE_LIMIT),
    .STEP_PRIME  (STEP_PRIME),
    .IDX_W       (IDX_W)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_kind_i   (req_if.kind),
    .req_key_i    (req_if.key),
    .cfg_valid_i  (cfg_if.valid),
    .cfg_data_i   (cfg_if.data),
    .rsp_ready_i  (rsp_if.ready),
    .rsp_valid_o  (rsp_if.valid),
    .rsp_status_o (rsp_if.status),
    .rsp_slot_o   (rsp_slot)
  );

  assign rsp_if.slot = rsp_slot;

endmodule

// ----- rtl/dht_checker.sv -----
module dht_checker #(
  parameter int SLOT_W = 4
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_valid_i,
  input logic                         req_ready_i,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic [dht_pkg::STATUS_W-1:0] rsp_status_i,
  input logic [SLOT_W-1:0]            rsp_slot_i
);
  import dht_pkg::*;

  // a pending response is held until taken
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped before transfer");

  // a stalled response keeps its payload
  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_status_i) && $stable(rsp_slot_i))
    else $error("response payload changed while stalled");

  // only inserted and found report a slot
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != ST_INSERTED && rsp_status_i != ST_FOUND
      |-> rsp_slot_i == '0)
    else $error("nonzero slot on a miss or failed insert");

  // one operation in flight: no request taken right after a transfer
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while an operation is busy");

endmodule

bind double_hash_table_top dht_checker #(
  .SLOT_W (IDX_W)
) u_dht_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_if.valid),
  .req_ready_i  (req_if.ready),
  .rsp_valid_i  (rsp_if.valid),
  .rsp_ready_i  (rsp_if.ready),
  .rsp_status_i (rsp_if.status),
  .rsp_slot_i   (rsp_if.slot)
);

// ----- verif/tb_double_hash_table_top.sv -----
module tb_double_hash_table_top;
  import dht_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 9;
  localparam int SLOT_W       = 4;
  localparam int DEPTH        = 16;
  localparam int PROBES       = 10;
  localparam int STEP_P       = 7;
  localparam int MAX_IDLE     = 18;
  localparam int PHASES       = 10;
  localparam int PHASE_OPS    = 103;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct packed {
    status_e           st;
    logic [SLOT_W-1:0] slot;
  } dht_result_t;

  typedef enum logic [1:0] {
    ROW_INSERT,
    ROW_SEARCH,
    ROW_SIZE
  } row_op_e;

  typedef struct packed {
    row_op_e           op;
    logic [KEY_W-1:0]  key;
    logic [CFG_W-1:0]  tsize;
    logic              typed;
    status_e           st;
    logic [SLOT_W-1:0] slot;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dht_req_if                   req_if ();
  dht_rsp_if #(.SLOT_W(SLOT_W)) rsp_if ();
  dht_cfg_if                   cfg_if ();

  double_hash_table_top #(
    .TABLE_DEPTH (DEPTH),
    .PROBE_LIMIT (PROBES),
    .STEP_PRIME  (STEP_P)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_if (req_if),
    .rsp_if (rsp_if),
    .cfg_if (cfg_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // shadow of the table contents and the size register
  logic [CFG_W-1:0] size_reg;
  logic [KEY_W-1:0] slot_key [DEPTH];
  logic             slot_used [DEPTH];
  int unsigned      occ_count;

  dht_result_t      pending_results [$];
  logic [KEY_W-1:0] key_pool [$];
  int               err_count = 0;
  bit               src_burst = 1'b0;
  bit               sink_burst = 1'b0;
  int               sink_wait = -1;

  logic [KEY_W-1:0] corner_keys [6] = '{31'h0000_0000, 31'h7fff_ffff, 31'h0000_0001,
                                        31'h7fff_fffe, 31'h4000_0000, 31'h3fff_ffff};

  // directed rows: expected results typed in only where obvious
  stim_row_t dir_rows [24] = '{
    '{ROW_SEARCH, 31'd5,          5'd0,  1'b1, ST_NOT_FOUND, 4'd0},
    '{ROW_INSERT, 31'd0,          5'd0,  1'b1, ST_INSERTED,  4'd0},
    '{ROW_SEARCH, 31'd0,          5'd0,  1'b1, ST_FOUND,     4'd0},
    '{ROW_INSERT, 31'd0,          5'd0,  1'b0, ST_INSERTED,  4'd0},
    '{ROW_INSERT, 31'h7fff_ffff,  5'd0,  1'b0, ST_INSERTED,  4'd0},
    '{ROW_SEARCH, 31'h7fff_ffff,  5'd0,  1'b0, ST_INSERTED,  4'd0},
    '{ROW_SEARCH, 31'd13,         5'd0,  1'b0, ST_INSERTED,  4'd0},
    '{ROW_SIZE,   31'd0,          5'd0,  1'b0, ST_INSERTED,  4'd0},
    '{ROW_INSERT, 31'd99,         5'd0,  1'b1, ST_FULL,      4'd0},
    '{ROW_SEARCH, 31'd0,          5'd0,  1'b1, ST_FOUND,     4'd0},
    '{ROW_SEARCH, 31'd12345,      5'd0,  1'b0, ST_INSERTED,  4'd0},
    '{ROW_SIZE,   31'd0,          5'd31, 1'b0, ST_INSERTED,  4'd0},
    '{ROW_INSERT, 31'd3,          5'd0,  1'b0, ST_INSERTED,  4'd0},
    '{ROW_INSERT, 31'd11,         5'd0,  1'b0, ST_INSERTED,  4'd0},
    '{ROW_INSERT, 31'd15,         5'd0,  1'b0, ST_INSERTED,  4'd0},
    '{ROW_INSERT, 31'd3,          5'd0,  1'b1, ST_NO_FREE,   4'd0},
    '{ROW_SEARCH, 31'd3,          5'd0,  1'b0, ST_INSERTED,  4'd0},
    '{ROW_SEARCH, 31'd19,         5'd0,  1'b0, ST_INSERTED,  4'd0},
    '{ROW_SIZE,   31'd0,          5'd1,  1'b0, ST_INSERTED,  4'd0},
    '{ROW_INSERT, 31'h2aaa_aaaa,  5'd0,  1'b1, ST_FULL,      4'd0},
    '{ROW_SIZE,   31'd0,          5'd16, 1'b0, ST_INSERTED,  4'd0},
    '{ROW_SEARCH, 31'h5555_5555,  5'd0,  1'b0, ST_INSERTED,  4'd0},
    '{ROW_INSERT, 31'h5555_5555,  5'd0,  1'b0, ST_INSERTED,  4'd0},
    '{ROW_SEARCH, 31'h7fff_ffff,  5'd0,  1'b0, ST_INSERTED,  4'd0}
  };

  // size in use: zero acts as one, above depth clamps
  function automatic int unsigned eff_size();
    if (size_reg == '0) return 1;
    if (size_reg > DEPTH) return DEPTH;
    return size_reg;
  endfunction

  // double hashing insert or lookup on the shadow table
  function automatic dht_result_t hash_predict(input logic op_kind,
                                               input logic [KEY_W-1:0] op_key);
    dht_result_t r;
    int unsigned n;
    int unsigned home;
    int unsigned probe_step;
    int unsigned idx;
    bit          done;
    n          = eff_size();
    home       = op_key % n;
    probe_step = STEP_P - op_key % STEP_P;
    r.slot     = '0;
    done       = 1'b0;
    if (op_kind == KIND_INSERT) begin
      if (occ_count >= n) begin
        r.st = ST_FULL;
      end else begin
        r.st = ST_NO_FREE;
        for (int i = 0; i <= PROBES && !done; i++) begin
          idx = (home + i * probe_step) % n;
          if (!slot_used[idx]) begin
            slot_used[idx] = 1'b1;
            slot_key[idx]  = op_key;
            occ_count++;
            r.st   = ST_INSERTED;
            r.slot = idx[SLOT_W-1:0];
            done   = 1'b1;
          end
        end
      end
    end else begin
      r.st = ST_NOT_FOUND;
      for (int i = 0; i <= PROBES && !done; i++) begin
        idx = (home + i * probe_step) % n;
        if (!slot_used[idx]) begin
          done = 1'b1;
        end else if (slot_key[idx] == op_key) begin
          r.st   = ST_FOUND;
          r.slot = idx[SLOT_W-1:0];
          done   = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic int draw_gap(input bit burst);
    if (burst || $urandom_range(0, 9) < 3) return 0;
    return $urandom_range(0, MAX_IDLE);
  endfunction

  // keys: stored keys, home-slot collisions, corners, full random
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned n;
    int unsigned r;
    int unsigned q;
    n = eff_size();
    r = $urandom_range(0, 99);
    if (r < 45 && key_pool.size() > 0) return key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (r < 70) begin
      q = $urandom_range(0, 32'h7fff_ffff / n - 1);
      return KEY_W'(q * n + $urandom_range(0, n - 1));
    end
    if (r < 82) return corner_keys[$urandom_range(0, 5)];
    return KEY_W'($urandom);
  endfunction

  // one request transfer, called and returning at a falling edge
  task automatic send_op(input logic op_kind, input logic [KEY_W-1:0] op_key,
                         input logic typed, input dht_result_t typed_res);
    int          gap;
    dht_result_t res;
    if ($urandom_range(0, 63) == 0) src_burst = !src_burst;
    gap = draw_gap(src_burst);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.kind  <= op_kind;
    req_if.key   <= op_key;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    res = hash_predict(op_kind, op_key);
    if (op_kind == KIND_INSERT) key_pool.push_back(op_key);
    pending_results.push_back(typed ? typed_res : res);
    @(negedge clk_i);
  endtask

  // size write once every pending response has come back
  task automatic write_size(input logic [CFG_W-1:0] tsize);
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= tsize;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    size_reg = tsize;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // response checking at the rising edge
  always @(posedge clk_i) begin : rsp_check
    dht_result_t exp_res;
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: response with nothing pending: status %0d slot %0d",
                 $time, rsp_if.status, rsp_if.slot);
        err_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (rsp_if.status !== exp_res.st) begin
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, exp_res.st, rsp_if.status);
          err_count++;
        end
        if (rsp_if.slot !== exp_res.slot) begin
          $display("%0t: slot mismatch: expected %0d, got %0d",
                   $time, exp_res.slot, rsp_if.slot);
          err_count++;
        end
      end
      sink_wait = -1;
      if ($urandom_range(0, 63) == 0) sink_burst = !sink_burst;
    end
  end

  // response stall: hold ready low for a drawn number of cycles of valid
  initial begin : rsp_ready_drive
    rsp_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (sink_wait < 0) sink_wait = draw_gap(sink_burst);
      if (sink_wait > 0) begin
        rsp_if.ready <= 1'b0;
        if (rsp_if.valid === 1'b1) sink_wait--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    logic             op_kind;
    logic [CFG_W-1:0] tsize;
    logic [CFG_W-1:0] phase_sizes [6];
    phase_sizes = '{5'd9, 5'd12, 5'd16, 5'd0, 5'd31, 5'd2};
    rst_ni        = 1'b0;
    req_if.valid  = 1'b0;
    req_if.kind   = KIND_INSERT;
    req_if.key    = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    size_reg      = SIZE_RESET;
    occ_count     = 0;
    for (int i = 0; i < DEPTH; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i]  = '0;
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part
    foreach (dir_rows[i]) begin
      case (dir_rows[i].op)
        ROW_SIZE: begin
          write_size(dir_rows[i].tsize);
        end
        default: begin
          op_kind = (dir_rows[i].op == ROW_INSERT) ? KIND_INSERT : KIND_SEARCH;
          send_op(op_kind, dir_rows[i].key, dir_rows[i].typed,
                  dht_result_t'{dir_rows[i].st, dir_rows[i].slot});
        end
      endcase
    end

    // random phases, each under its own table size
    for (int p = 0; p < PHASES; p++) begin
      if (p < 6) tsize = phase_sizes[p];
      else if ($urandom_range(0, 3) == 0) tsize = CFG_W'($urandom_range(0, SIZE_MAX));
      else tsize = CFG_W'($urandom_range(8, DEPTH));
      write_size(tsize);
      src_burst = (p % 3 == 2);
      for (int j = 0; j < PHASE_OPS; j++) begin
        op_kind = ($urandom_range(0, 99) < 35) ? KIND_INSERT : KIND_SEARCH;
        send_op(op_kind, pick_key(), 1'b0, dht_result_t'{ST_INSERTED, 4'd0});
      end
    end

    // drain
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
